### rtl/core/bfa_pkg.sv
// Shared types, codes and helpers for the bitmap frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

    localparam int FRAME_W     = 12;
    localparam int CFG_W       = 13;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = 5;
    localparam int SCAN_W      = FRAME_W - BIT_W;
    localparam int FRAME_LIMIT = 4096;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_ALLOCATED     = 3'd0,
        ST_ALREADY       = 3'd1,
        ST_OUT_OF_FRAMES = 3'd2,
        ST_FREED         = 3'd3,
        ST_NOTHING       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               command;
        logic [FRAME_W-1:0] entry_frame;
        logic               kernel_only;
        logic               want_writable;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [FRAME_W-1:0] result_frame;
        logic               present;
        logic               writable;
        logic               user_access;
    } t_out_item;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/bfa_engine.sv
// Allocator sequencer: clearing pass, bitmap scan and read-modify-write of bitmap words.
`timescale 1ns / 1ps
`default_nettype none

module bfa_engine
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 4096,
    localparam int WORDS     = (MAX_FRAMES + 31) / 32,
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CFG_W-1:0]  i_frame_count,
    input  wire logic              i_req_vld,
    output logic                   o_req_stall,
    input  wire t_in_item          i_req,
    output logic                   o_res_vld,
    output t_out_item              o_res,
    input  wire logic              i_res_ready,
    output logic                   o_mem_we,
    output logic      [AW-1:0]     o_mem_waddr,
    output logic      [WORD_W-1:0] o_mem_wdata,
    output logic                   o_mem_re,
    output logic      [AW-1:0]     o_mem_raddr,
    input  wire logic [WORD_W-1:0] i_mem_rdata
);

    localparam int CAP = (MAX_FRAMES < FRAME_LIMIT) ? MAX_FRAMES : FRAME_LIMIT;
    localparam int XW  = (AW > SCAN_W) ? AW : SCAN_W;

    t_state            r_state, n_state;
    t_in_item          r_req;
    t_out_item         r_res, n_res;
    logic [SCAN_W-1:0] r_idx;
    logic [AW-1:0]     r_clr;

    logic [CFG_W-1:0]  w_limit;
    logic [CFG_W-1:0]  w_lim_m1;
    logic [SCAN_W-1:0] w_last;
    logic [WORD_W-1:0] w_mask;
    logic [WORD_W-1:0] w_free;
    logic              w_hit;
    logic [BIT_W-1:0]  w_pos;
    logic              w_accept;
    logic              w_entry_nz;
    logic              w_in_range;
    logic              w_at_last;
    logic [XW-1:0]     w_x_next, w_x_cur, w_x_req, w_x_acc;

    // Search limit is the smallest of the register, the bitmap size and the frame field.
    assign w_limit  = (i_frame_count > CFG_W'(CAP)) ? CFG_W'(CAP) : i_frame_count;
    assign w_lim_m1 = w_limit - CFG_W'(1);
    assign w_last   = w_lim_m1[FRAME_W-1:BIT_W];
    assign w_at_last = (r_idx == w_last);
    assign w_mask   = w_at_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - w_lim_m1[BIT_W-1:0]))
                                : {WORD_W{1'b1}};
    assign w_free   = ~i_mem_rdata & w_mask;
    assign w_hit    = |w_free;
    assign w_pos    = lowest_set(w_free);

    assign w_accept   = (r_state == S_IDLE) && i_req_vld;
    assign w_entry_nz = (i_req.entry_frame != '0);
    assign w_in_range = (32'(i_req.entry_frame) < 32'(MAX_FRAMES));

    assign w_x_next = XW'(r_idx + SCAN_W'(1));
    assign w_x_cur  = XW'(r_idx);
    assign w_x_req  = XW'(r_req.entry_frame[FRAME_W-1:BIT_W]);
    assign w_x_acc  = XW'(i_req.entry_frame[FRAME_W-1:BIT_W]);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_vld) begin
                    if (i_req.command == CMD_ALLOC) begin
                        n_state = (w_entry_nz || w_limit == '0) ? S_DONE : S_SCAN;
                    end else begin
                        n_state = (w_entry_nz && w_in_range) ? S_FREE : S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit || w_at_last) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Memory controls and result
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        n_res       = r_res;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_res = '{status: ST_NOTHING, result_frame: '0,
                              present: 1'b0, writable: 1'b0, user_access: 1'b0};
                    if (i_req.command == CMD_ALLOC) begin
                        if (w_entry_nz) begin
                            n_res.status       = ST_ALREADY;
                            n_res.result_frame = i_req.entry_frame;
                        end else begin
                            n_res.status = ST_OUT_OF_FRAMES;
                            o_mem_re     = 1'b1;
                        end
                    end else if (w_entry_nz) begin
                        n_res.status = ST_FREED;
                        o_mem_re     = w_in_range;
                        o_mem_raddr  = w_x_acc[AW-1:0];
                    end
                end
            end
            S_SCAN: begin
                o_mem_re    = !w_hit && !w_at_last;
                o_mem_raddr = w_x_next[AW-1:0];
                if (w_hit) begin
                    o_mem_we           = 1'b1;
                    o_mem_waddr        = w_x_cur[AW-1:0];
                    o_mem_wdata        = i_mem_rdata | (WORD_W'(1) << w_pos);
                    n_res.status       = ST_ALLOCATED;
                    n_res.result_frame = {r_idx, w_pos};
                    n_res.present      = 1'b1;
                    n_res.writable     = r_req.want_writable;
                    n_res.user_access  = ~r_req.kernel_only;
                end
            end
            S_FREE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = w_x_req[AW-1:0];
                o_mem_wdata = i_mem_rdata & ~(WORD_W'(1) << r_req.entry_frame[BIT_W-1:0]);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_accept) begin
            r_req <= i_req;
            r_idx <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + SCAN_W'(1);
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_vld   = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

### rtl/core/bitmap_frame_allocator.sv
// Top level of the bitmap page frame allocator: config register, bitmap RAM, sequencer, output.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_wdata (frame_count)
//
// Allocation: an allocate into an empty entry scans one bitmap word per cycle through the
//   single RAM read port, at most ceil(L/32) words, L = min(frame_count, MAX_FRAMES,
//   4096); a free that clears a bit reads its bitmap word and writes it back.
// Reset: a clearing pass writes all (MAX_FRAMES+31)/32 bitmap words, one per cycle,
//   before the first transaction is taken; config writes are taken during it.
// Stalls: the output register holds a result while the next transaction is worked on.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int WORDS = (MAX_FRAMES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [CFG_W-1:0]  r_frame_count;
    logic              r_out_vld;
    t_out_item         r_out;

    logic              w_res_vld;
    t_out_item         w_res;
    logic              w_res_ready;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [WORD_W-1:0] w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    logic [WORD_W-1:0] w_mem_rdata;

    // Frame count: the user must write it only while no transaction is in flight (unenforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= CFG_W'(FRAME_LIMIT);
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    // Used-frame bitmap: bit (f mod 32) of word (f / 32) marks frame f in use.
    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    bfa_engine #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_count (r_frame_count),
        .i_req_vld     (i_in_valid),
        .o_req_stall   (o_in_stall),
        .i_req         (i_in_data),
        .o_res_vld     (w_res_vld),
        .o_res         (w_res),
        .i_res_ready   (w_res_ready),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_re      (w_mem_re),
        .o_mem_raddr   (w_mem_raddr),
        .i_mem_rdata   (w_mem_rdata)
    );

    // Output slot is free when empty or being drained this cycle.
    assign w_res_ready = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld && w_res_ready) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Load payload only on handover; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (w_res_vld && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
